>>> rtl/phml_pkg.sv
// ----------------------------------------------------------------------------
// phml_pkg
// Shared widths, register indexes and the configuration bundle of the
// heading PID motor loop.
// ----------------------------------------------------------------------------
package phml_pkg;

  localparam int ANGLE_W    = 32;
  localparam int GAIN_W     = 24;
  localparam int VEL_W      = 7;
  localparam int TOL_W      = 16;
  localparam int ERR_W      = ANGLE_W + 1;
  localparam int DERIV_W    = ERR_W + 1;
  localparam int DRIVE_W    = 8;
  localparam int SUM_W      = 64;
  localparam int P_W        = GAIN_W + ERR_W;
  localparam int D_W        = GAIN_W + DERIV_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Integral product is split into a low and a high partial product
  localparam int SPLIT_W    = 32;

  // Defaults for the top level parameters
  localparam int ANGLE_FRAC_BITS_DEF = 8;
  localparam int GAIN_FRAC_BITS_DEF  = 16;
  localparam int INTEGRAL_WIDTH_DEF  = 48;

  // Integral clear window, whole degrees
  localparam int CLEAR_LOW_DEG  = 10;
  localparam int CLEAR_HIGH_DEG = 180;

  // Integral term saturates at +-2^62
  localparam int SAT_TERM_LOG2 = 62;

  localparam logic [VEL_W-1:0] MAX_VEL_RESET = 7'd127;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET  = 3'd0,
    REG_GAIN_P  = 3'd1,
    REG_GAIN_I  = 3'd2,
    REG_GAIN_D  = 3'd3,
    REG_MAX_VEL = 3'd4,
    REG_TOL     = 3'd5,
    REG_ENABLE  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] target_angle;
    logic signed [GAIN_W-1:0]  gain_p;
    logic signed [GAIN_W-1:0]  gain_i;
    logic signed [GAIN_W-1:0]  gain_d;
    logic [VEL_W-1:0]          max_velocity;
    logic [TOL_W-1:0]          tolerance;
    logic                      loop_enable;
  } cfg_t;

endpackage

>>> rtl/phml_cfg.sv
// ----------------------------------------------------------------------------
// phml_cfg
// Configuration register file; one register written per transaction.
// ----------------------------------------------------------------------------
module phml_cfg import phml_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_angle <= '0;
      cfg.gain_p       <= '0;
      cfg.gain_i       <= '0;
      cfg.gain_d       <= '0;
      cfg.max_velocity <= MAX_VEL_RESET;
      cfg.tolerance    <= '0;
      cfg.loop_enable  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_TARGET:  cfg.target_angle <= $signed(cfg_data[ANGLE_W-1:0]);
        REG_GAIN_P:  cfg.gain_p       <= $signed(cfg_data[GAIN_W-1:0]);
        REG_GAIN_I:  cfg.gain_i       <= $signed(cfg_data[GAIN_W-1:0]);
        REG_GAIN_D:  cfg.gain_d       <= $signed(cfg_data[GAIN_W-1:0]);
        REG_MAX_VEL: cfg.max_velocity <= cfg_data[VEL_W-1:0];
        REG_TOL:     cfg.tolerance    <= cfg_data[TOL_W-1:0];
        REG_ENABLE:  cfg.loop_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/phml_front.sv
// ----------------------------------------------------------------------------
// phml_front
// Input register and error stage: error, saturating integral with clear
// window, derivative and at-target band test. Holds the loop state.
// ----------------------------------------------------------------------------
module phml_front import phml_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int INTEGRAL_WIDTH  = INTEGRAL_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  cfg_t                             cfg,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [ANGLE_W-1:0]        measured_angle,
  output logic                             s1_valid,
  input  logic                             s1_ready,
  output logic signed [ERR_W-1:0]          s1_err,
  output logic signed [DERIV_W-1:0]        s1_deriv,
  output logic signed [INTEGRAL_WIDTH-1:0] s1_integral,
  output logic                             s1_inside
);

  localparam int W = INTEGRAL_WIDTH;
  localparam logic signed [W-1:0] IMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] IMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [ERR_W-1:0] CLR_LO = ERR_W'(CLEAR_LOW_DEG) << ANGLE_FRAC_BITS;
  localparam logic [ERR_W-1:0] CLR_HI = ERR_W'(CLEAR_HIGH_DEG) << ANGLE_FRAC_BITS;

  logic                       v0;
  logic signed [ANGLE_W-1:0]  angle;
  logic                       ready0;
  logic                       ready1;
  logic                       ld1;
  logic signed [ERR_W-1:0]    err;
  logic [ERR_W-1:0]           err_mag;
  logic [ERR_W-1:0]           band;
  logic signed [W:0]          isum;
  logic signed [W-1:0]        integ_sat;
  logic signed [W-1:0]        integral_next;
  logic                       clr;
  logic signed [W-1:0]        integral;
  logic signed [ERR_W-1:0]    prev_err;
  logic signed [DERIV_W-1:0]  deriv;
  logic signed [DERIV_W-1:0]  deriv_next;
  logic                       in_band;
  logic                       v1;

  assign ready1   = !v1 || s1_ready;
  assign ready0   = !v0 || ready1;
  assign in_stall = !ready0;
  assign ld1      = v0 && ready1;

  // Input register; a transaction while the loop is off is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (ready0) begin
      v0 <= in_valid && cfg.loop_enable;
    end
  end

  always_ff @(posedge clk) begin
    if (ready0 && in_valid) begin
      angle <= measured_angle;
    end
  end

  assign err = $signed({cfg.target_angle[ANGLE_W-1], cfg.target_angle})
             - $signed({angle[ANGLE_W-1], angle});
  assign err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

  assign isum = $signed({integral[W-1], integral})
              + $signed({{(W+1-ERR_W){err[ERR_W-1]}}, err});

  always_comb begin
    if (isum[W] != isum[W-1]) begin
      integ_sat = isum[W] ? IMIN : IMAX;
    end else begin
      integ_sat = isum[W-1:0];
    end
  end

  assign clr           = (err_mag < CLR_LO) || (err_mag > CLR_HI);
  assign integral_next = clr ? '0 : integ_sat;

  assign deriv_next = $signed({err[ERR_W-1], err})
                    - $signed({prev_err[ERR_W-1], prev_err});

  // angle inside target +- band is the same as |target - angle| < band
  assign band   = ERR_W'(cfg.tolerance) << ANGLE_FRAC_BITS;

  // Loop state; it also serves as the stage 1 payload since it only moves
  // together with the item that stands in stage 1.
  always_ff @(posedge clk) begin
    if (rst) begin
      integral <= '0;
      prev_err <= '0;
    end else if (ld1) begin
      integral <= integral_next;
      prev_err <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      deriv   <= deriv_next;
      in_band <= err_mag < band;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= v0;
    end
  end

  assign s1_valid    = v1;
  assign s1_err      = prev_err;
  assign s1_deriv    = deriv;
  assign s1_integral = integral;
  assign s1_inside   = in_band;

`ifndef SYNTHESIS
  a_clear_window: assert property (@(posedge clk) disable iff (rst)
    (ld1 && clr) |=> (integral == '0))
    else $error("integral not cleared inside clear window");

  a_no_wrap_pos: assert property (@(posedge clk) disable iff (rst)
    (ld1 && !integral[W-1] && !err[ERR_W-1]) |=> !integral[W-1])
    else $error("integral wrapped negative");

  a_no_wrap_neg: assert property (@(posedge clk) disable iff (rst)
    (ld1 && integral[W-1] && err[ERR_W-1]) |=> (integral[W-1] || integral == '0))
    else $error("integral wrapped positive");
`endif

endmodule

>>> rtl/phml_terms.sv
// ----------------------------------------------------------------------------
// phml_terms
// Gain products. Stage 2 forms the P and D products and the two partial
// products of the integral term; stage 3 merges and saturates the latter.
// ----------------------------------------------------------------------------
module phml_terms import phml_pkg::*; #(
  parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  cfg_t                             cfg,
  input  logic                             s1_valid,
  output logic                             s1_ready,
  input  logic signed [ERR_W-1:0]          s1_err,
  input  logic signed [DERIV_W-1:0]        s1_deriv,
  input  logic signed [INTEGRAL_WIDTH-1:0] s1_integral,
  input  logic                             s1_inside,
  output logic                             s3_valid,
  input  logic                             s3_ready,
  output logic signed [P_W-1:0]            s3_p,
  output logic signed [D_W-1:0]            s3_d,
  output logic signed [SUM_W-1:0]          s3_i,
  output logic                             s3_inside
);

  localparam int W       = INTEGRAL_WIDTH;
  localparam int HI_W    = W - SPLIT_W;
  localparam int LO_PP_W = GAIN_W + SPLIT_W;
  localparam int HI_PP_W = GAIN_W + HI_W;
  localparam int FULL_W  = GAIN_W + W + 1;
  localparam int CW      = (FULL_W > SUM_W) ? FULL_W : SUM_W;
  localparam logic [CW-1:0] SAT_LIM = CW'(1) << SAT_TERM_LOG2;

  logic                      v2;
  logic                      v3;
  logic                      ready2;
  logic                      ready3;
  logic signed [P_W-1:0]     p_prod;
  logic signed [D_W-1:0]     d_prod;
  logic [GAIN_W-1:0]         gi_mag;
  logic [W-1:0]              x_mag;
  logic [LO_PP_W-1:0]        pp_lo_prod;
  logic [HI_PP_W-1:0]        pp_hi_prod;
  logic signed [P_W-1:0]     p2;
  logic signed [D_W-1:0]     d2;
  logic [LO_PP_W-1:0]        pp_lo;
  logic [HI_PP_W-1:0]        pp_hi;
  logic                      neg2;
  logic                      inside2;
  logic [CW-1:0]             full;
  logic [SUM_W-1:0]          i_mag;
  logic signed [SUM_W-1:0]   i_term;

  assign ready3   = !v3 || s3_ready;
  assign ready2   = !v2 || ready3;
  assign s1_ready = ready2;

  assign p_prod = $signed(cfg.gain_p) * $signed(s1_err);
  assign d_prod = $signed(cfg.gain_d) * $signed(s1_deriv);

  // Integral term in sign-magnitude so the saturation works on magnitudes
  assign gi_mag = cfg.gain_i[GAIN_W-1] ? GAIN_W'(-cfg.gain_i) : GAIN_W'(cfg.gain_i);
  assign x_mag  = s1_integral[W-1] ? W'(-s1_integral) : W'(s1_integral);
  assign pp_lo_prod = gi_mag * x_mag[SPLIT_W-1:0];
  assign pp_hi_prod = gi_mag * x_mag[W-1:SPLIT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && s1_valid) begin
      p2      <= p_prod;
      d2      <= d_prod;
      pp_lo   <= pp_lo_prod;
      pp_hi   <= pp_hi_prod;
      neg2    <= cfg.gain_i[GAIN_W-1] ^ s1_integral[W-1];
      inside2 <= s1_inside;
    end
  end

  assign full  = (CW'(pp_hi) << SPLIT_W) + CW'(pp_lo);
  assign i_mag = (full > SAT_LIM) ? SAT_LIM[SUM_W-1:0] : full[SUM_W-1:0];
  assign i_term = neg2 ? -$signed(i_mag) : $signed(i_mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && v2) begin
      s3_p      <= p2;
      s3_d      <= d2;
      s3_i      <= i_term;
      s3_inside <= inside2;
    end
  end

  assign s3_valid = v3;

endmodule

>>> rtl/phml_drive.sv
// ----------------------------------------------------------------------------
// phml_drive
// Term sum, truncation toward zero to whole units, velocity clamp and the
// output register.
// ----------------------------------------------------------------------------
module phml_drive import phml_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int GAIN_FRAC_BITS  = GAIN_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cfg_t                      cfg,
  input  logic                      s3_valid,
  output logic                      s3_ready,
  input  logic signed [P_W-1:0]     s3_p,
  input  logic signed [D_W-1:0]     s3_d,
  input  logic signed [SUM_W-1:0]   s3_i,
  input  logic                      s3_inside,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [DRIVE_W-1:0] drive_command,
  output logic                      at_target
);

  localparam int SH  = ANGLE_FRAC_BITS + GAIN_FRAC_BITS;
  localparam int Q_W = SUM_W - SH;

  logic                     v4;
  logic                     ready4;
  logic                     ready5;
  logic signed [SUM_W-1:0]  sum_next;
  logic signed [SUM_W-1:0]  sum;
  logic                     inside4;
  logic signed [Q_W-1:0]    q_floor;
  logic signed [Q_W-1:0]    q;
  logic                     frac_nz;
  logic signed [Q_W-1:0]    vmax;
  logic signed [Q_W-1:0]    vmin;
  logic signed [DRIVE_W-1:0] drive_next;

  assign ready5   = !out_valid || !out_stall;
  assign ready4   = !v4 || ready5;
  assign s3_ready = ready4;

  assign sum_next = $signed({{(SUM_W-P_W){s3_p[P_W-1]}}, s3_p})
                  + $signed({{(SUM_W-D_W){s3_d[D_W-1]}}, s3_d})
                  + s3_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (ready4) begin
      v4 <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready4 && s3_valid) begin
      sum     <= sum_next;
      inside4 <= s3_inside;
    end
  end

  // Shift floors; a negative sum with dropped fraction bits steps back up
  assign q_floor = sum[SUM_W-1:SH];
  assign frac_nz = |sum[SH-1:0];
  assign q       = q_floor + $signed(Q_W'(sum[SUM_W-1] && frac_nz));

  assign vmax = $signed(Q_W'(cfg.max_velocity));
  assign vmin = -vmax;

  always_comb begin
    if (q > vmax) begin
      drive_next = vmax[DRIVE_W-1:0];
    end else if (q < vmin) begin
      drive_next = vmin[DRIVE_W-1:0];
    end else begin
      drive_next = q[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready5) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (ready5 && v4) begin
      drive_command <= drive_next;
      at_target     <= inside4;
    end
  end

endmodule

>>> rtl/pid_heading_motor_loop.sv
// ----------------------------------------------------------------------------
// pid_heading_motor_loop
// PID heading loop with integral clear window, saturating integral and
// clamped drive output, plus an at-target flag.
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// in       sink       in_valid / in_stall    measured_angle
// out      source     out_valid / out_stall  drive_command, at_target
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction per cycle sustained while out_stall stays low; a result
// passes input reg, error stage, products, integral merge, sum and output
// reg in turn. The integral/previous-error update closes in the error stage.
// Each stage advances when it is empty or the next one moves, so bubbles
// are squeezed out under out_stall; in_stall rises only when all are full.
// Inputs taken while loop_enable is clear are dropped with no result.
// Synchronous reset clears valids, loop state and registers to defaults.
// ----------------------------------------------------------------------------
module pid_heading_motor_loop import phml_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int GAIN_FRAC_BITS  = GAIN_FRAC_BITS_DEF,
  parameter int INTEGRAL_WIDTH  = INTEGRAL_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [ANGLE_W-1:0] measured_angle,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [DRIVE_W-1:0] drive_command,
  output logic                      at_target,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  cfg_t                             cfg;
  logic                             s1_valid;
  logic                             s1_ready;
  logic signed [ERR_W-1:0]          s1_err;
  logic signed [DERIV_W-1:0]        s1_deriv;
  logic signed [INTEGRAL_WIDTH-1:0] s1_integral;
  logic                             s1_inside;
  logic                             s3_valid;
  logic                             s3_ready;
  logic signed [P_W-1:0]            s3_p;
  logic signed [D_W-1:0]            s3_d;
  logic signed [SUM_W-1:0]          s3_i;
  logic                             s3_inside;

  phml_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  phml_front #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .INTEGRAL_WIDTH  (INTEGRAL_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .measured_angle (measured_angle),
    .s1_valid       (s1_valid),
    .s1_ready       (s1_ready),
    .s1_err         (s1_err),
    .s1_deriv       (s1_deriv),
    .s1_integral    (s1_integral),
    .s1_inside      (s1_inside)
  );

  phml_terms #(
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) u_terms (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .s1_valid    (s1_valid),
    .s1_ready    (s1_ready),
    .s1_err      (s1_err),
    .s1_deriv    (s1_deriv),
    .s1_integral (s1_integral),
    .s1_inside   (s1_inside),
    .s3_valid    (s3_valid),
    .s3_ready    (s3_ready),
    .s3_p        (s3_p),
    .s3_d        (s3_d),
    .s3_i        (s3_i),
    .s3_inside   (s3_inside)
  );

  phml_drive #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .GAIN_FRAC_BITS  (GAIN_FRAC_BITS)
  ) u_drive (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .s3_valid      (s3_valid),
    .s3_ready      (s3_ready),
    .s3_p          (s3_p),
    .s3_d          (s3_d),
    .s3_i          (s3_i),
    .s3_inside     (s3_inside),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .drive_command (drive_command),
    .at_target     (at_target)
  );

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output side is moving");

  a_drive_symmetric: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive_command != $signed({1'b1, {(DRIVE_W-1){1'b0}}})))
    else $error("drive command outside the symmetric range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("pipeline not empty after reset");
`endif

endmodule

>>> tb/sv/pid_heading_motor_loop_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_heading_motor_loop_tb
// Self-checking bench for the heading PID loop. Runs a short directed table
// (output extremes, truncation, tolerance edges, clear window, disabled
// ticks), then random register settings and angles. Each accepted angle goes
// through a local loop model, and the returned commands are compared in order.
// ----------------------------------------------------------------------------
module pid_heading_motor_loop_tb;
  import phml_pkg::*;

  localparam int AFB           = ANGLE_FRAC_BITS_DEF;
  localparam int GFB           = GAIN_FRAC_BITS_DEF;
  localparam int INT_W         = INTEGRAL_WIDTH_DEF;
  localparam int DEG           = 1 << AFB;
  localparam int ONE_GAIN      = 1 << GFB;
  localparam int LIVE_ITEMS    = 1750;
  localparam int SETTLE_CYCLES = 10;
  // index with no register behind it; writes must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      at;
  } motor_cmd_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_TICK, ROW_CHECK} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  value;
    motor_cmd_t             cmd;
  } plan_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [ANGLE_W-1:0] measured_angle = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [DRIVE_W-1:0] drive_command;
  logic                      at_target;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  // loop model state
  cfg_t                    loop_cfg;
  logic signed [INT_W-1:0] err_integral;
  logic signed [ERR_W-1:0] last_err;
  motor_cmd_t              cmd_q[$];

  int fails = 0;
  int snd_idle = 35;
  int rcv_idle = 87;
  int live_items = 0;
  bit dirty = 1'b0;

  pid_heading_motor_loop dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .measured_angle (measured_angle),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .drive_command  (drive_command),
    .at_target      (at_target),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("[pid_heading_motor_loop] ERROR");
    $finish;
  end

  // One control tick; returns 0 when the loop is disabled (no command).
  function automatic bit loop_tick(input logic signed [ANGLE_W-1:0] angle,
                                   output motor_cmd_t cmd);
    logic signed [127:0] tgt, ang, err, acc, deriv, mag, lim, term_i, total, drv, vmax, band;
    cmd = '0;
    if (!loop_cfg.loop_enable) return 1'b0;
    tgt = $signed(loop_cfg.target_angle);
    ang = angle;
    err = tgt - ang;
    lim = (128'sd1 <<< (INT_W - 1)) - 128'sd1;
    acc = err_integral + err;
    if (acc > lim) acc = lim;
    else if (acc < -lim - 128'sd1) acc = -lim - 128'sd1;
    deriv = err - last_err;
    last_err = err[ERR_W-1:0];
    // clear after the add, outside the 10..180 degree window
    mag = (err < 0) ? -err : err;
    if (mag < CLEAR_LOW_DEG * DEG || mag > CLEAR_HIGH_DEG * DEG) acc = '0;
    err_integral = acc[INT_W-1:0];
    lim = 128'sd1 <<< SAT_TERM_LOG2;
    term_i = $signed(loop_cfg.gain_i) * acc;
    if (term_i > lim) term_i = lim;
    else if (term_i < -lim) term_i = -lim;
    total = $signed(loop_cfg.gain_p) * err + term_i + $signed(loop_cfg.gain_d) * deriv;
    drv = total / (128'sd1 <<< (AFB + GFB));
    vmax = loop_cfg.max_velocity;
    if (drv > vmax) drv = vmax;
    if (drv < -vmax) drv = -vmax;
    band = loop_cfg.tolerance;
    band = band <<< AFB;
    cmd.drive = drv[DRIVE_W-1:0];
    cmd.at = (ang > tgt - band) && (ang < tgt + band);
    return 1'b1;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_TARGET:  loop_cfg.target_angle = data[ANGLE_W-1:0];
      REG_GAIN_P:  loop_cfg.gain_p = data[GAIN_W-1:0];
      REG_GAIN_I:  loop_cfg.gain_i = data[GAIN_W-1:0];
      REG_GAIN_D:  loop_cfg.gain_d = data[GAIN_W-1:0];
      REG_MAX_VEL: loop_cfg.max_velocity = data[VEL_W-1:0];
      REG_TOL:     loop_cfg.tolerance = data[TOL_W-1:0];
      REG_ENABLE:  loop_cfg.loop_enable = data[0];
      default: ;
    endcase
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] value);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.value = value;
    return r;
  endfunction

  function automatic plan_row_t tick_row(input logic [ANGLE_W-1:0] angle);
    plan_row_t r;
    r = '0;
    r.kind = ROW_TICK;
    r.value = angle;
    return r;
  endfunction

  function automatic plan_row_t check_row(input logic [ANGLE_W-1:0] angle, input int drive,
                                          input logic at);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CHECK;
    r.value = angle;
    r.cmd.drive = drive[DRIVE_W-1:0];
    r.cmd.at = at;
    return r;
  endfunction

  // random junk above a narrow register's width
  function automatic logic [CFG_DATA_W-1:0] pad(input logic [CFG_DATA_W-1:0] v, input int w);
    return $urandom_range(0, 1) ? v : (v | ($urandom << w));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_gain();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'h0080_0000;
      2: return 32'h007F_FFFF;
      3: return $urandom_range(0, 2 * ONE_GAIN) - ONE_GAIN;
      4: return $urandom_range(0, ONE_GAIN / 2) - ONE_GAIN / 4;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_target();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(0, 720 * DEG) - 360 * DEG;
    endcase
  endfunction

  function automatic logic [ANGLE_W-1:0] rand_angle();
    int offs;
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: begin
        // edges of the integral clear window
        offs = ($urandom_range(0, 1) ? CLEAR_LOW_DEG : CLEAR_HIGH_DEG) * DEG
               + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1)) offs = -offs;
      end
      3: begin
        // edges of the at-target band
        offs = loop_cfg.tolerance * DEG + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1)) offs = -offs;
      end
      default: offs = $urandom_range(0, 400 * DEG) - 200 * DEG;
    endcase
    return loop_cfg.target_angle + offs;
  endfunction

  task automatic send_tick(input logic [ANGLE_W-1:0] angle, input bit typed,
                           input motor_cmd_t typed_cmd);
    motor_cmd_t cmd;
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    measured_angle <= angle;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    dirty = 1'b1;
    if (loop_tick(angle, cmd)) begin
      if (typed) cmd = typed_cmd;
      cmd_q.push_back(cmd);
      live_items++;
    end
  endtask

  // Wait for every command, plus margin for dropped ticks still in flight.
  task automatic settle();
    in_valid <= 1'b0;
    while (cmd_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    dirty = 1'b0;
  endtask

  task automatic drain_hold();
    in_valid <= 1'b0;
    do @(posedge clk); while (cmd_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    if (dirty) settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase();
    int n;
    int hold_at;
    write_reg(REG_TARGET, rand_target());
    write_reg(REG_GAIN_P, rand_gain());
    write_reg(REG_GAIN_I, rand_gain());
    write_reg(REG_GAIN_D, rand_gain());
    case ($urandom_range(0, 3))
      0: write_reg(REG_MAX_VEL, pad(0, VEL_W));
      1: write_reg(REG_MAX_VEL, pad(MAX_VEL_RESET, VEL_W));
      default: write_reg(REG_MAX_VEL, pad($urandom_range(0, 127), VEL_W));
    endcase
    case ($urandom_range(0, 5))
      0: write_reg(REG_TOL, pad(0, TOL_W));
      1: write_reg(REG_TOL, pad(16'hFFFF, TOL_W));
      2: write_reg(REG_TOL, pad($urandom_range(0, 65535), TOL_W));
      default: write_reg(REG_TOL, pad($urandom_range(0, 300), TOL_W));
    endcase
    write_reg(REG_ENABLE, pad($urandom_range(0, 7) != 0, 1));
    n = loop_cfg.loop_enable ? $urandom_range(30, 90) : $urandom_range(4, 12);
    hold_at = $urandom_range(0, 2 * n);
    for (int k = 0; k < n; k++) begin
      if (k == hold_at) drain_hold();
      send_tick(rand_angle(), 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin : result_check
    motor_cmd_t want;
    if (!rst && out_valid && !out_stall) begin
      if (cmd_q.size() == 0) begin
        $error("drive_command: no command expected, got %0d", drive_command);
        fails++;
      end else begin
        want = cmd_q.pop_front();
        if (drive_command !== want.drive) begin
          $error("drive_command: expected %0d, got %0d", $signed(want.drive), drive_command);
          fails++;
        end
        if (at_target !== want.at) begin
          $error("at_target: expected %0b, got %0b", want.at, at_target);
          fails++;
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < rcv_idle);
  end

  initial begin : stimulus
    plan_row_t plan[$];
    loop_cfg = '0;
    loop_cfg.max_velocity = MAX_VEL_RESET;
    err_integral = '0;
    last_err = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // proportional-only first, so commands can be typed in
    plan.push_back(cfg_row(REG_TARGET, 0));
    plan.push_back(cfg_row(REG_GAIN_P, ONE_GAIN));
    plan.push_back(cfg_row(REG_GAIN_I, 0));
    plan.push_back(cfg_row(REG_GAIN_D, 0));
    plan.push_back(cfg_row(REG_MAX_VEL, MAX_VEL_RESET));
    plan.push_back(cfg_row(REG_TOL, 5));
    plan.push_back(cfg_row(REG_ENABLE, 1));
    plan.push_back(cfg_row(REG_SPARE, 32'hFFFF_FFFF));
    plan.push_back(check_row(0, 0, 1'b1));
    plan.push_back(check_row(-12800, 50, 1'b0));
    plan.push_back(check_row(12800, -50, 1'b0));
    plan.push_back(check_row(32'h7FFF_FFFF, -127, 1'b0));
    plan.push_back(check_row(32'h8000_0000, 127, 1'b0));
    plan.push_back(check_row(1279, -4, 1'b1));
    plan.push_back(check_row(-1279, 4, 1'b1));
    plan.push_back(check_row(1280, -5, 1'b0));
    plan.push_back(check_row(-1280, 5, 1'b0));
    plan.push_back(cfg_row(REG_MAX_VEL, 0));
    plan.push_back(check_row(-12800, 0, 1'b0));
    // integral and derivative, around the clear window
    plan.push_back(cfg_row(REG_MAX_VEL, MAX_VEL_RESET));
    plan.push_back(cfg_row(REG_GAIN_I, ONE_GAIN));
    plan.push_back(cfg_row(REG_GAIN_D, ONE_GAIN));
    plan.push_back(tick_row(-20 * DEG));
    plan.push_back(tick_row(-20 * DEG));
    plan.push_back(tick_row(-10 * DEG + 1));
    plan.push_back(tick_row(-10 * DEG));
    plan.push_back(tick_row(-180 * DEG));
    plan.push_back(tick_row(-180 * DEG - 1));
    // disabled tick leaves the state alone
    plan.push_back(cfg_row(REG_ENABLE, 0));
    plan.push_back(tick_row(-20 * DEG));
    plan.push_back(cfg_row(REG_ENABLE, 1));
    plan.push_back(tick_row(-20 * DEG));
    plan.push_back(cfg_row(REG_TOL, 0));
    plan.push_back(tick_row(0));
    plan.push_back(cfg_row(REG_GAIN_P, 32'hFF80_0000));
    plan.push_back(cfg_row(REG_GAIN_D, 32'h007F_FFFF));
    plan.push_back(tick_row(32'h7FFF_FFFF));
    plan.push_back(tick_row(32'h8000_0000));
    plan.push_back(cfg_row(REG_TARGET, 32'h7FFF_FFFF));
    plan.push_back(tick_row(32'h8000_0000));

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CFG:  write_reg(plan[i].idx, plan[i].value);
        ROW_TICK: send_tick(plan[i].value, 1'b0, plan[i].cmd);
        default:  send_tick(plan[i].value, 1'b1, plan[i].cmd);
      endcase
    end

    while (live_items < LIVE_ITEMS) begin
      if (live_items < LIVE_ITEMS / 3) begin
        snd_idle = 35;
        rcv_idle = 87;
      end else if (live_items < 2 * LIVE_ITEMS / 3) begin
        snd_idle = 87;
        rcv_idle = 35;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      random_phase();
    end

    settle();
    if (fails == 0) begin
      $display("[pid_heading_motor_loop] OK");
    end else begin
      $display("[pid_heading_motor_loop] ERROR");
    end
    $finish;
  end

endmodule
